// ===== rtl/rsi_pkg.sv =====
// Shared constants, widths and state encodings for the relative strength index block.
package rsi_pkg;

    localparam int PRICE_BITS  = 32;
    localparam int WINDOW_MAX  = 256;
    localparam int WIN_W       = 9;
    localparam int POS_W       = $clog2(WINDOW_MAX);
    localparam int CHG_W       = PRICE_BITS + 1;
    localparam int SUM_W       = PRICE_BITS + POS_W + 1;
    localparam int TOT_W       = SUM_W + 1;
    localparam int QUO_W       = 15;
    localparam int CNT_W       = $clog2(QUO_W);

    // 25600 = 25 * 2^10; the divider takes G*25 and appends the ten zero bits.
    localparam int RSI_SHIFT   = 10;
    localparam int NUM_W       = SUM_W + 5;
    localparam int NUM_LOW_W   = QUO_W - RSI_SHIFT;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(14);
    localparam logic [QUO_W-1:0] RSI_HALF     = QUO_W'(12800);
    localparam logic [QUO_W-1:0] RSI_FULL     = QUO_W'(25600);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_EVICT,
        ST_ADD,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } rsi_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_LOAD,
        DV_STEP
    } div_state_t;

endpackage

// ===== rtl/relative_strength_index.sv =====
// Top level of the relative strength index block: window history, sums and sequencer.
//
// Usage
//   Input stream (s_*): one transaction per price sample. s_tdata carries the price
//   in ticks, s_tuser the restart flag that starts a new series with this sample.
//   Output stream (m_*): one transaction per input transaction. m_tdata carries
//   RSI * 256 truncated (0..25600, 12800 when gain and loss sums are both zero);
//   m_tuser is high once more than window_length samples of the series are in.
//   While m_tuser is low the RSI field is zero.
//   cfg_we/cfg_wdata write window_length (0 acts as 1, above 256 acts as 256);
//   a write also clears the history. Write only while the block is idle.
// Sequencing
//   Each sample passes through START and READ. The first sample of a series then goes
//   to OUT; later ones pass EVICT, ADD and CHECK, then the 15-step bit-serial divider
//   when the window is full and the sums are not both zero, then OUT. The next sample
//   is taken only once the block is back in IDLE.
// Reset and stall
//   Reset clears the history, sets window_length to 14 and empties the output.
//   A result waiting on a stalled receiver does not block the next input
//   transaction; that sample's result holds inside until the output register frees.
module relative_strength_index
    import rsi_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [WIN_W-1:0]       cfg_wdata,      // window_length
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,        // [31:0] price
    input  logic                   s_tuser,        // [0] restart
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,        // [14:0] rsi_scaled, [15] zero
    output logic                   m_tuser         // [0] ready_res
);

    rsi_state_t            state_reg, state_next;

    logic [WIN_W-1:0]      win_reg;
    logic [PRICE_BITS-1:0] prev_reg;
    logic [SUM_W-1:0]      gain_reg;
    logic [SUM_W-1:0]      loss_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [WIN_W-1:0]      seen_reg;

    logic [PRICE_BITS-1:0] price_reg;
    logic                  restart_reg;
    logic [CHG_W-1:0]      change_reg;
    logic                  evict_reg;
    logic [QUO_W-1:0]      res_rsi_reg;
    logic                  res_ready_reg;

    logic                  m_tvalid_reg;
    logic [QUO_W-1:0]      m_rsi_reg;
    logic                  m_ready_reg;

    logic [WIN_W-1:0]      w_used;
    logic [WIN_W-1:0]      pos_inc;
    logic                  window_full;
    logic                  sums_zero;
    logic [TOT_W-1:0]      total;
    logic [CHG_W-1:0]      old_change;

    logic                  ram_we;
    logic                  div_start;
    logic                  div_done;
    logic [QUO_W-1:0]      div_quotient;
    logic                  out_load;

    // clamp the programmed window into 1..WINDOW_MAX
    always_comb begin
        if (win_reg == '0) begin
            w_used = WIN_W'(1);
        end else if (win_reg > WIN_W'(WINDOW_MAX)) begin
            w_used = WIN_W'(WINDOW_MAX);
        end else begin
            w_used = win_reg;
        end
    end

    assign pos_inc     = WIN_W'(pos_reg) + 1'b1;
    assign window_full = seen_reg > w_used;
    assign sums_zero   = (gain_reg == '0) && (loss_reg == '0);
    assign total       = TOT_W'(gain_reg) + TOT_W'(loss_reg);

    // ring of the last window_length signed changes
    rsi_ram #(
        .WIDTH (CHG_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (pos_reg),
        .wr_data (change_reg),
        .rd_addr (pos_reg),
        .rd_data (old_change)
    );

    rsi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .gain     (gain_reg),
        .total    (total),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_READ;
            ST_READ: begin
                // first sample of a series only records the price
                state_next = (seen_reg == '0) ? ST_OUT : ST_EVICT;
            end
            ST_EVICT: state_next = ST_ADD;
            ST_ADD:   state_next = ST_CHECK;
            ST_CHECK: begin
                state_next = (window_full && !sums_zero) ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_EVICT: ram_we    = 1'b1;
            ST_CHECK: div_start = window_full && !sums_zero;
            ST_OUT:   out_load  = !m_tvalid_reg || m_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // window register and running history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= WINDOW_RESET;
            prev_reg <= '0;
            gain_reg <= '0;
            loss_reg <= '0;
            pos_reg  <= '0;
            seen_reg <= '0;
        end else if (cfg_we) begin
            // a new window drops the whole history
            win_reg  <= cfg_wdata;
            prev_reg <= '0;
            gain_reg <= '0;
            loss_reg <= '0;
            pos_reg  <= '0;
            seen_reg <= '0;
        end else begin
            case (state_reg)
                ST_START: begin
                    if (restart_reg) begin
                        prev_reg <= '0;
                        gain_reg <= '0;
                        loss_reg <= '0;
                        pos_reg  <= '0;
                        seen_reg <= '0;
                    end
                end
                ST_READ: begin
                    if (seen_reg == '0) begin
                        prev_reg <= price_reg;
                        seen_reg <= WIN_W'(1);
                    end
                end
                ST_EVICT: begin
                    // drop the oldest change once the ring is full
                    if (evict_reg) begin
                        if (!old_change[CHG_W-1]) begin
                            gain_reg <= gain_reg - SUM_W'(old_change[PRICE_BITS-1:0]);
                        end else begin
                            loss_reg <= loss_reg
                                + {{(SUM_W-CHG_W){old_change[CHG_W-1]}}, old_change};
                        end
                    end
                end
                ST_ADD: begin
                    // zero change counts as a gain
                    if (!change_reg[CHG_W-1]) begin
                        gain_reg <= gain_reg + SUM_W'(change_reg[PRICE_BITS-1:0]);
                    end else begin
                        loss_reg <= loss_reg
                            - {{(SUM_W-CHG_W){change_reg[CHG_W-1]}}, change_reg};
                    end
                    pos_reg  <= (pos_inc == w_used) ? '0 : pos_inc[POS_W-1:0];
                    prev_reg <= price_reg;
                    if (seen_reg <= w_used) begin
                        seen_reg <= seen_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // per-sample working registers and the pending result
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    price_reg   <= s_tdata[PRICE_BITS-1:0];
                    restart_reg <= s_tuser;
                end
            end
            ST_READ: begin
                change_reg    <= {1'b0, price_reg} - {1'b0, prev_reg};
                evict_reg     <= window_full;
                res_rsi_reg   <= '0;
                res_ready_reg <= 1'b0;
            end
            ST_CHECK: begin
                res_ready_reg <= window_full;
                res_rsi_reg   <= !window_full ? '0 : RSI_HALF;
            end
            ST_DIV: begin
                if (div_done) begin
                    res_rsi_reg <= div_quotient;
                end
            end
            default: begin
            end
        endcase
    end

    // output register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_rsi_reg   <= res_rsi_reg;
            m_ready_reg <= res_ready_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-QUO_W){1'b0}}, m_rsi_reg};
    assign m_tuser  = m_ready_reg;

    // history counters stay inside the window
    property p_seen_bounded;
        @(posedge aclk) disable iff (!aresetn)
        ({1'b0, seen_reg} <= ({1'b0, w_used} + 1'b1));
    endproperty
    a_seen_bounded: assert property (p_seen_bounded)
        else $error("sample count beyond window plus one");

    property p_pos_bounded;
        @(posedge aclk) disable iff (!aresetn)
        (WIN_W'(pos_reg) < w_used);
    endproperty
    a_pos_bounded: assert property (p_pos_bounded)
        else $error("ring position outside window");

    property p_div_done_in_wait;
        @(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV);
    endproperty
    a_div_done_in_wait: assert property (p_div_done_in_wait)
        else $error("divider finished outside the wait state");

    property p_not_ready_zero;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_ready_reg) |-> (m_rsi_reg == '0);
    endproperty
    a_not_ready_zero: assert property (p_not_ready_zero)
        else $error("nonzero RSI on a not-ready result");

    property p_rsi_range;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_rsi_reg <= RSI_FULL);
    endproperty
    a_rsi_range: assert property (p_rsi_range)
        else $error("RSI above full scale");

endmodule

// ===== rtl/rsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsi_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rsi_div.sv =====
// Bit-serial long divider: quotient = floor(25600 * gain / total), one bit per cycle.
module rsi_div
    import rsi_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] gain,
    input  logic [TOT_W-1:0] total,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    div_state_t       dstate_reg, dstate_next;
    logic [SUM_W-1:0] g_reg;
    logic [TOT_W-1:0] t_reg;
    logic [NUM_W-1:0] acc_reg;
    logic [TOT_W-1:0] rem_reg;
    logic [QUO_W-1:0] nbits_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [NUM_W-1:0] num25;
    logic [TOT_W:0]   trial;
    logic [TOT_W:0]   diff;
    logic             trial_ge;
    logic             last_step;

    // numerator is G*25; top part seeds the remainder, low bits shift in serially
    assign num25    = acc_reg + NUM_W'(g_reg);
    assign trial    = {rem_reg, nbits_reg[QUO_W-1]};
    assign diff     = trial - {1'b0, t_reg};
    assign trial_ge = trial >= {1'b0, t_reg};

    always_comb begin
        dstate_next = dstate_reg;
        case (dstate_reg)
            DV_IDLE: begin
                if (start) begin
                    dstate_next = DV_LOAD;
                end
            end
            DV_LOAD: dstate_next = DV_STEP;
            DV_STEP: begin
                if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                    dstate_next = DV_IDLE;
                end
            end
            default: dstate_next = DV_IDLE;
        endcase
    end

    always_comb begin
        last_step = (dstate_reg == DV_STEP) && (cnt_reg == CNT_W'(QUO_W - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dstate_reg <= DV_IDLE;
            done_reg   <= 1'b0;
        end else begin
            dstate_reg <= dstate_next;
            done_reg   <= last_step;
        end
    end

    always_ff @(posedge aclk) begin
        case (dstate_reg)
            DV_IDLE: begin
                if (start) begin
                    g_reg   <= gain;
                    t_reg   <= total;
                    acc_reg <= (NUM_W'(gain) << 4) + (NUM_W'(gain) << 3);
                end
            end
            DV_LOAD: begin
                rem_reg   <= TOT_W'(num25[NUM_W-1:NUM_LOW_W]);
                nbits_reg <= {num25[NUM_LOW_W-1:0], {RSI_SHIFT{1'b0}}};
                cnt_reg   <= '0;
            end
            DV_STEP: begin
                rem_reg   <= trial_ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
                quo_reg   <= {quo_reg[QUO_W-2:0], trial_ge};
                nbits_reg <= {nbits_reg[QUO_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // remainder must stay below the divisor through every step
    property p_rem_below_divisor;
        @(posedge aclk) disable iff (!aresetn)
        (dstate_reg == DV_STEP) |-> (rem_reg < t_reg);
    endproperty
    a_rem_below_divisor: assert property (p_rem_below_divisor)
        else $error("divider remainder not below divisor");

    property p_done_after_step;
        @(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(dstate_reg) == DV_STEP) && (dstate_reg == DV_IDLE);
    endproperty
    a_done_after_step: assert property (p_done_after_step)
        else $error("divider done without a final step");

    property p_quotient_range;
        @(posedge aclk) disable iff (!aresetn)
        done_reg |-> (quo_reg <= RSI_FULL);
    endproperty
    a_quotient_range: assert property (p_quotient_range)
        else $error("divider quotient above full scale");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the relative strength index block with its own RSI predictor.
`timescale 1ns / 100ps

module tb_top;
    import rsi_pkg::*;

    localparam int STALL_LIMIT = 2000;   // cycles without any transaction before giving up
    localparam int TAIL_CYCLES = 40;     // quiet time after the last result

    typedef enum logic [1:0] {
        ITEM_SAMPLE,
        ITEM_WRITE,
        ITEM_DRAIN
    } item_kind_t;

    typedef struct {
        item_kind_t       kind;
        logic [31:0]      price;
        logic             restart;
        logic [WIN_W-1:0] wlen;
        int               phase;
    } stim_item_t;

    typedef struct packed {
        logic [QUO_W-1:0] rsi;
        logic             rdy;
    } rsi_result_t;

    // Clock, reset and block ports; every input starts at a known value.
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [WIN_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;      // [31:0] price
    logic                   s_tuser = 1'b0;    // [0] restart
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // [14:0] rsi_scaled, [15] zero
    logic                   m_tuser;           // [0] ready_res

    relative_strength_index uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Pending stimulus and expected results.
    stim_item_t  item_q[$];
    rsi_result_t rsi_exp_q[$];
    int          sent = 0;      // input transactions taken, updated by the driver
    int          got = 0;       // results matched against an expectation, by the monitor
    int          err_count = 0;
    int          phase = 0;     // idle pattern in force, follows the item at the head
    int          gen_phase = 0;
    logic [31:0] gen_prev = '0;

    // Predictor state.
    logic [WIN_W-1:0]   win_len = WINDOW_RESET;
    logic [31:0]        px_prev;
    logic signed [32:0] chg_ring [WINDOW_MAX];
    int unsigned        ring_pos;
    logic [63:0]        gain_acc;
    logic [63:0]        loss_acc;
    int unsigned        seen_cnt;

    // Idle percentage per phase: sender 21 / receiver 65, then swapped, then none.
    function automatic int idle_pct(input int ph, input bit rx_side);
        case (ph)
            0:       return rx_side ? 65 : 21;
            1:       return rx_side ? 21 : 65;
            default: return 0;
        endcase
    endfunction

    function automatic void history_clear();
        for (int i = 0; i < WINDOW_MAX; i++) chg_ring[i] = '0;
        px_prev  = '0;
        ring_pos = 0;
        gain_acc = '0;
        loss_acc = '0;
        seen_cnt = 0;
    endfunction

    // Advance the window by one price sample and return the RSI it yields.
    function automatic rsi_result_t rsi_predict(input logic [31:0] price, input logic restart);
        rsi_result_t        res;
        int unsigned        w;
        logic signed [32:0] delta;
        logic signed [32:0] gone;
        logic [63:0]        total;
        w = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : win_len);
        if (ring_pos >= w) ring_pos = 0;
        if (seen_cnt > w + 1) seen_cnt = w + 1;
        if (restart) history_clear();
        if (seen_cnt == 0) begin
            // first sample of a series: record the price only
            px_prev  = price;
            seen_cnt = 1;
        end else begin
            delta = $signed({1'b0, price}) - $signed({1'b0, px_prev});
            if (seen_cnt - 1 >= w) begin
                // ring full: evict the oldest change from its sum
                gone = chg_ring[ring_pos];
                if (gone >= 0) gain_acc -= 64'(gone);
                else loss_acc -= 64'(-gone);
            end
            // a zero change counts as a gain of zero
            if (delta >= 0) gain_acc += 64'(delta);
            else loss_acc += 64'(-delta);
            chg_ring[ring_pos] = delta;
            ring_pos++;
            if (ring_pos >= w) ring_pos = 0;
            px_prev = price;
            if (seen_cnt < w + 1) seen_cnt++;
        end
        res.rdy = (seen_cnt > w);
        res.rsi = '0;
        if (res.rdy) begin
            total = gain_acc + loss_acc;
            if (total == 0) res.rsi = RSI_HALF;
            else res.rsi = QUO_W'((64'(RSI_FULL) * gain_acc) / total);
        end
        return res;
    endfunction

    task automatic push_sample(input logic [31:0] price, input logic restart);
        stim_item_t it;
        it = '{kind: ITEM_SAMPLE, price: price, restart: restart, wlen: '0, phase: gen_phase};
        item_q.push_back(it);
        gen_prev = price;
    endtask

    task automatic push_write(input logic [WIN_W-1:0] wlen);
        stim_item_t it;
        it = '{kind: ITEM_WRITE, price: '0, restart: 1'b0, wlen: wlen, phase: gen_phase};
        item_q.push_back(it);
    endtask

    task automatic push_drain();
        stim_item_t it;
        it = '{kind: ITEM_DRAIN, price: '0, restart: 1'b0, wlen: '0, phase: gen_phase};
        item_q.push_back(it);
    endtask

    // One window setting followed by a random price walk mixed with jumps and extremes.
    task automatic run_segment(input logic [WIN_W-1:0] wlen, input int count,
                               input int restart_pct);
        logic [31:0] p;
        logic        r;
        push_write(wlen);
        for (int i = 0; i < count; i++) begin
            r = ($urandom_range(0, 99) < restart_pct);
            case ($urandom_range(0, 9))
                0:       p = $urandom();
                1:       p = '0;
                2:       p = '1;
                3, 4:    p = gen_prev;
                default: p = gen_prev + $urandom_range(0, 2000) - 1000;
            endcase
            push_sample(p, r);
            if ($urandom_range(0, 199) == 0) push_drain();
        end
    endtask

    // Driver: present samples, fire register writes once the block has drained,
    // and run the predictor on every input transaction.
    always @(posedge aclk) begin : drive_proc
        stim_item_t  head;
        logic        hand;
        logic        valid_nxt;
        logic        we_nxt;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= 1'b0;
            cfg_we    <= 1'b0;
            cfg_wdata <= '0;
            history_clear();
            win_len = WINDOW_RESET;
        end else begin
            hand   = s_tvalid && s_tready;
            we_nxt = 1'b0;
            if (hand) begin
                rsi_exp_q.push_back(rsi_predict(s_tdata, s_tuser));
                sent <= sent + 1;
            end
            if (!s_tvalid || hand) begin
                valid_nxt = 1'b0;
                if (item_q.size() != 0) begin
                    head = item_q[0];
                    phase <= head.phase;
                    case (head.kind)
                        ITEM_SAMPLE: begin
                            if ($urandom_range(0, 99) >= idle_pct(head.phase, 1'b0)) begin
                                void'(item_q.pop_front());
                                valid_nxt = 1'b1;
                                s_tdata   <= head.price;
                                s_tuser   <= head.restart;
                            end
                        end
                        ITEM_DRAIN: begin
                            // hold off until every expected result has come back
                            if (!hand && sent == got) void'(item_q.pop_front());
                        end
                        ITEM_WRITE: begin
                            // write only into an idle block; the write clears history
                            if (!hand && sent == got && s_tready && !cfg_we) begin
                                void'(item_q.pop_front());
                                we_nxt    = 1'b1;
                                cfg_wdata <= head.wlen;
                                win_len = head.wlen;
                                history_clear();
                            end
                        end
                        default: ;
                    endcase
                end
                s_tvalid <= valid_nxt;
            end
            cfg_we <= we_nxt;
        end
    end

    // Monitor: stall at random and compare each result with the oldest expectation.
    always @(posedge aclk) begin : mon_proc
        rsi_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (got >= sent) begin
                    $error("result with no expectation: rsi_scaled %0d ready_res %0b",
                           m_tdata[QUO_W-1:0], m_tuser);
                    err_count++;
                end else begin
                    want = rsi_exp_q.pop_front();
                    got <= got + 1;
                    if (m_tdata[QUO_W-1:0] !== want.rsi) begin
                        $error("rsi_scaled: expected %0d, actual %0d",
                               want.rsi, m_tdata[QUO_W-1:0]);
                        err_count++;
                    end
                    if (m_tuser !== want.rdy) begin
                        $error("ready_res: expected %0b, actual %0b", want.rdy, m_tuser);
                        err_count++;
                    end
                    if (m_tdata[OUT_TDATA_W-1:QUO_W] !== '0) begin
                        $error("tdata pad: expected 0, actual %0b",
                               m_tdata[OUT_TDATA_W-1:QUO_W]);
                        err_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct(phase, 1'b1));
        end
    end

    // Watchdog: end the run when no transaction of any kind happens for too long.
    always @(posedge aclk) begin : dog_proc
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stim_proc
        // Directed: reset window, first sample, not ready, restart.
        gen_phase = 0;
        push_sample(32'd100, 1'b0);
        push_sample(32'd250, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);
        push_drain();
        // Window 0 acts as 1: full gain, full loss, no movement, restart.
        push_write('0);
        push_sample(32'd0, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b0);
        push_sample(32'd0, 1'b0);
        push_sample(32'd0, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1);
        push_sample(32'd0, 1'b0);
        // Window 2: flat prices, then mixed gains and losses, then a window with no gains.
        push_write(WIN_W'(2));
        push_sample(32'd10, 1'b0);
        push_sample(32'd10, 1'b0);
        push_sample(32'd10, 1'b0);
        push_sample(32'd11, 1'b0);
        push_sample(32'd9, 1'b0);
        push_sample(32'd9, 1'b0);

        // Random part; wide windows get long series without restarts.
        run_segment(WIN_W'(3), 120, 4);
        run_segment(WIN_W'(0), 60, 5);
        run_segment(WIN_W'(20), 150, 2);
        run_segment(WIN_W'(511), 300, 0);
        gen_phase = 1;
        run_segment(WIN_W'(1), 80, 5);
        run_segment(WIN_W'(256), 290, 0);
        run_segment(WIN_W'(7), 150, 3);
        gen_phase = 2;
        run_segment(WIN_W'(14), 150, 3);
        run_segment(WIN_W'(257), 280, 0);
        run_segment(WIN_W'(5), 70, 3);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (item_q.size() != 0 || sent != got) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0 && sent == got && rsi_exp_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
